>>> hdl/cma_pkg.sv
package cma_pkg;

  // field formats
  localparam int unsigned SYM_TABLE   = 24;
  localparam int unsigned SYM_OPS_DEF = 24;
  localparam int unsigned OPW         = 18;
  localparam int unsigned SUMW        = 38;
  localparam int unsigned TAB_IDX_W   = 5;

  localparam logic [30:0] W_ONE      = 31'h4000_0000;
  localparam logic [15:0] ANGLE_MAX  = 16'd46080;
  localparam logic [24:0] DEG90      = 25'd5898240;
  localparam logic [4:0]  CORDIC_LAST = 5'd16;
  localparam logic [15:0] THRESH_RST = 16'd3840;

  // register indexes
  localparam logic REG_THRESH = 1'b0;

  // symmetry constants in Q.15
  localparam logic signed [17:0] QO  = 18'sd32768;
  localparam logic signed [17:0] QR  = 18'sd23170;
  localparam logic signed [17:0] QH  = 18'sd16384;
  localparam logic signed [17:0] QNR = -18'sd23170;
  localparam logic signed [17:0] QNH = -18'sd16384;
  localparam logic signed [17:0] QZ  = 18'sd0;

  typedef struct packed {
    logic signed [15:0] first_w;
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] first_z;
    logic signed [15:0] second_w;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
    logic signed [15:0] second_z;
  } cma_in_t;

  typedef struct packed {
    logic [15:0] angle_degrees;
    logic        is_low_angle;
  } cma_out_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_ROT,
    OP_PAIR,
    OP_SQR
  } dot_op_e;

  // travels with each operation through the shared unit
  typedef struct packed {
    dot_op_e                op;
    logic                   side;
    logic [TAB_IDX_W-1:0]   idx;
    logic [1:0]             comp;
  } dot_tag_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROT,
    S_GAP,
    S_PAIR,
    S_SAT,
    S_SQR,
    S_SQW,
    S_GO,
    S_ACOS,
    S_OUT
  } cma_state_e;

  typedef enum logic [1:0] {
    A_IDLE,
    A_ROOT,
    A_CORD,
    A_DONE
  } acos_state_e;

  typedef struct packed {
    logic        done;
    logic [15:0] angle;
  } acos_stat_t;

  // cubic symmetry rotation as {w, x, y, z}
  function automatic logic [4*OPW-1:0] sym_row(logic [TAB_IDX_W-1:0] idx);
    logic [4*OPW-1:0] r;
    unique case (idx)
      5'd0:    r = {QO, QZ, QZ, QZ};
      5'd1:    r = {QZ, QO, QZ, QZ};
      5'd2:    r = {QR, QR, QZ, QZ};
      5'd3:    r = {QR, QNR, QZ, QZ};
      5'd4:    r = {QZ, QZ, QO, QZ};
      5'd5:    r = {QZ, QZ, QZ, QO};
      5'd6:    r = {QZ, QZ, QR, QNR};
      5'd7:    r = {QZ, QZ, QR, QR};
      5'd8:    r = {QR, QZ, QZ, QNR};
      5'd9:    r = {QH, QH, QH, QNH};
      5'd10:   r = {QZ, QR, QR, QZ};
      5'd11:   r = {QH, QNH, QNH, QNH};
      5'd12:   r = {QR, QZ, QZ, QR};
      5'd13:   r = {QH, QH, QNH, QH};
      5'd14:   r = {QZ, QR, QNR, QZ};
      5'd15:   r = {QH, QNH, QH, QH};
      5'd16:   r = {QR, QZ, QR, QZ};
      5'd17:   r = {QH, QH, QH, QH};
      5'd18:   r = {QZ, QR, QZ, QR};
      5'd19:   r = {QH, QNH, QH, QNH};
      5'd20:   r = {QR, QZ, QNR, QZ};
      5'd21:   r = {QH, QH, QNH, QNH};
      5'd22:   r = {QZ, QR, QZ, QNR};
      5'd23:   r = {QH, QNH, QNH, QH};
      default: r = {QO, QZ, QZ, QZ};
    endcase
    return r;
  endfunction

  // arctan(2^-k) in degrees, Q.16
  function automatic logic [24:0] atan_deg(logic [4:0] k);
    logic [24:0] a;
    unique case (k)
      5'd0:    a = 25'd2949120;
      5'd1:    a = 25'd1740967;
      5'd2:    a = 25'd919879;
      5'd3:    a = 25'd466945;
      5'd4:    a = 25'd234379;
      5'd5:    a = 25'd117305;
      5'd6:    a = 25'd58666;
      5'd7:    a = 25'd29335;
      5'd8:    a = 25'd14668;
      5'd9:    a = 25'd7334;
      5'd10:   a = 25'd3667;
      5'd11:   a = 25'd1833;
      5'd12:   a = 25'd917;
      5'd13:   a = 25'd458;
      5'd14:   a = 25'd229;
      5'd15:   a = 25'd115;
      5'd16:   a = 25'd57;
      default: a = 25'd0;
    endcase
    return a;
  endfunction

endpackage

>>> hdl/cma_dot4.sv
module cma_dot4 import cma_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic signed [OPW-1:0]  a_i [4],
  input  logic signed [OPW-1:0]  b_i [4],
  input  dot_tag_t               tag_i,
  output logic signed [SUMW-1:0] sum_o,
  output dot_tag_t               tag_o
);

  logic signed [2*OPW-1:0] prod [4];
  logic signed [SUMW-1:0]  sum_q;
  dot_tag_t                tag_q;

  // four products and their sum
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      prod[k] = a_i[k] * b_i[k];
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= SUMW'(prod[0]) + SUMW'(prod[1]) + SUMW'(prod[2]) + SUMW'(prod[3]);
  end

  // tag follows the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '{op: OP_NONE, side: 1'b0, idx: '0, comp: '0};
    end else begin
      tag_q <= tag_i;
    end
  end

  assign sum_o = sum_q;
  assign tag_o = tag_q;

endmodule

>>> hdl/cma_acos.sv
module cma_acos import cma_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [30:0] w_i,
  input  logic [60:0] v_i,
  output acos_stat_t  stat_o
);

  acos_state_e state_q, state_d;

  logic [60:0]        rem_q, rem_d;
  logic [61:0]        res_q, res_d;
  logic [60:0]        bit_q, bit_d;
  logic signed [33:0] x_q, x_d, y_q, y_d;
  logic signed [24:0] acc_q, acc_d;
  logic [4:0]         k_q, k_d;

  logic [61:0]        trial;
  logic [61:0]        res_next;
  logic signed [33:0] xs, ys;
  logic [24:0]        acc_sat;
  logic [24:0]        acc_rnd;
  logic [15:0]        angle;

  // one square root step and one cordic step per cycle
  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    res_d   = res_q;
    bit_d   = bit_q;
    x_d     = x_q;
    y_d     = y_q;
    acc_d   = acc_q;
    k_d     = k_q;
    trial   = res_q + 62'(bit_q);
    if (62'(rem_q) >= trial) begin
      res_next = (res_q >> 1) + 62'(bit_q);
    end else begin
      res_next = res_q >> 1;
    end
    xs = x_q >>> k_q;
    ys = y_q >>> k_q;
    unique case (state_q)
      A_IDLE: begin
        if (start_i) begin
          rem_d   = v_i;
          res_d   = '0;
          bit_d   = 61'(1) << 60;
          state_d = A_ROOT;
        end
      end
      A_ROOT: begin
        if (62'(rem_q) >= trial) begin
          rem_d = 61'(62'(rem_q) - trial);
        end
        res_d = res_next;
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          x_d     = $signed({3'b000, w_i});
          y_d     = $signed({3'b000, res_next[30:0]});
          acc_d   = '0;
          k_d     = '0;
          state_d = A_CORD;
        end
      end
      A_CORD: begin
        if (!y_q[33]) begin
          x_d   = x_q + ys;
          y_d   = y_q - xs;
          acc_d = acc_q + $signed(atan_deg(k_q));
        end else begin
          x_d   = x_q - ys;
          y_d   = y_q + xs;
          acc_d = acc_q - $signed(atan_deg(k_q));
        end
        k_d = k_q + 5'd1;
        if (k_q == CORDIC_LAST) begin
          state_d = A_DONE;
        end
      end
      A_DONE: begin
        state_d = A_IDLE;
      end
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
    bit_q <= bit_d;
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
    k_q   <= k_d;
  end

  // clamp to 0..90 degrees, double and round to Q8.8
  always_comb begin
    if (acc_q[24]) begin
      acc_sat = '0;
    end else if ($unsigned(acc_q) > DEG90) begin
      acc_sat = DEG90;
    end else begin
      acc_sat = $unsigned(acc_q);
    end
    acc_rnd = acc_sat + 25'd64;
    angle   = (acc_rnd[22:7] > ANGLE_MAX) ? ANGLE_MAX : acc_rnd[22:7];
  end

  assign stat_o.done  = (state_q == A_DONE);
  assign stat_o.angle = angle;

endmodule

>>> hdl/cubic_misorientation_angle_unit.sv
// Misorientation angle between two cubic orientations given as Q1.15
// quaternions. Each item is rotated by the cubic symmetry operators, all
// pairings are compared on one shared four-lane multiply-add unit and the
// largest |scalar| is turned into 2*acos in degrees (Q8.8) by a square root
// and a cordic stage. From an accepted transfer the item passes through the
// multiply-add unit, one rotated component or one pairing per cycle, then
// through 31 square root steps and 17 cordic steps. The input stalls until
// the result is loaded into its own output register; a finished result
// waits there, so the next item can be taken while it is unread.
// is_low_angle is set when the angle is below the low_angle_threshold
// register (byte address 0, Q8.8 degrees, reset 15 degrees).
module cubic_misorientation_angle_unit import cma_pkg::*; #(
  parameter int unsigned SymOps = SYM_OPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  cma_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output cma_out_t    out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IdxW = (SymOps > 1) ? $clog2(SymOps) : 1;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(SymOps - 1);

  cma_state_e state_q, state_d;

  logic [15:0]        thresh_q;
  cma_in_t            in_q;
  logic [IdxW-1:0]    ci_q, ci_d, cj_q, cj_d;
  logic               side_q, side_d;
  logic [1:0]         comp_q, comp_d;
  logic signed [17:0] ra_q [SymOps][4];
  logic signed [17:0] rb_q [SymOps][4];
  logic [37:0]        best_q;
  logic [60:0]        ww_q;
  logic [15:0]        angle_q;
  logic               out_vld_q;
  cma_out_t           out_q;

  logic signed [17:0] opa [4];
  logic signed [17:0] opb [4];
  logic signed [17:0] qv  [4];
  logic signed [17:0] sv  [4];
  logic [4*OPW-1:0]   row;
  dot_tag_t           tag_in, tag_out;
  logic signed [37:0] dsum;
  logic signed [37:0] rsum;
  logic [37:0]        dabs;
  logic [30:0]        wsat;
  logic [60:0]        vrad;
  logic               acos_start;
  acos_stat_t         acos_stat;
  logic               in_take, out_load;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_THRESH) ? {16'b0, thresh_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RST;
    end else if (psel && penable && pwrite && (paddr[2] == REG_THRESH)) begin
      thresh_q <= pwdata[15:0];
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;

  // sequencer
  always_comb begin
    state_d    = state_q;
    ci_d       = ci_q;
    cj_d       = cj_q;
    side_d     = side_q;
    comp_d     = comp_q;
    acos_start = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ci_d    = '0;
          cj_d    = '0;
          side_d  = 1'b0;
          comp_d  = '0;
          state_d = S_ROT;
        end
      end
      S_ROT: begin
        comp_d = comp_q + 2'd1;
        if (comp_q == 2'd3) begin
          side_d = !side_q;
          if (side_q) begin
            ci_d = ci_q + 1'b1;
            if (ci_q == IdxLast) begin
              ci_d    = '0;
              state_d = S_GAP;
            end
          end
        end
      end
      S_GAP: state_d = S_PAIR;
      S_PAIR: begin
        cj_d = cj_q + 1'b1;
        if (cj_q == IdxLast) begin
          cj_d = '0;
          ci_d = ci_q + 1'b1;
          if (ci_q == IdxLast) begin
            state_d = S_SAT;
          end
        end
      end
      S_SAT: begin
        comp_d  = '0;
        state_d = S_SQR;
      end
      S_SQR: begin
        comp_d = comp_q + 2'd1;
        if (comp_q == 2'd2) begin
          state_d = S_SQW;
        end
      end
      S_SQW: state_d = S_GO;
      S_GO: begin
        acos_start = 1'b1;
        state_d    = S_ACOS;
      end
      S_ACOS: begin
        if (acos_stat.done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_vld_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ci_q   <= ci_d;
    cj_q   <= cj_d;
    side_q <= side_d;
    comp_q <= comp_d;
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (acos_stat.done) begin
      angle_q <= acos_stat.angle;
    end
  end

  // operands for the shared unit
  assign row   = sym_row(TAB_IDX_W'(ci_q));
  assign sv[0] = $signed(row[71:54]);
  assign sv[1] = $signed(row[53:36]);
  assign sv[2] = $signed(row[35:18]);
  assign sv[3] = $signed(row[17:0]);
  assign wsat  = (best_q > 38'(W_ONE)) ? W_ONE : best_q[30:0];

  always_comb begin
    if (side_q) begin
      qv[0] = 18'(in_q.second_w);
      qv[1] = 18'(in_q.second_x);
      qv[2] = 18'(in_q.second_y);
      qv[3] = 18'(in_q.second_z);
    end else begin
      qv[0] = 18'(in_q.first_w);
      qv[1] = 18'(in_q.first_x);
      qv[2] = 18'(in_q.first_y);
      qv[3] = 18'(in_q.first_z);
    end
    for (int k = 0; k < 4; k++) begin
      opa[k] = '0;
      opb[k] = '0;
    end
    tag_in = '{op: OP_NONE, side: side_q, idx: TAB_IDX_W'(ci_q), comp: comp_q};
    unique case (state_q)
      S_ROT: begin
        tag_in.op = OP_ROT;
        opa[0] = sv[0];
        case (comp_q)
          2'd0: begin
            opa[1] = -sv[1]; opa[2] = -sv[2]; opa[3] = -sv[3];
            opb[0] = qv[0];  opb[1] = qv[1];  opb[2] = qv[2];  opb[3] = qv[3];
          end
          2'd1: begin
            opa[1] = sv[1];  opa[2] = sv[2];  opa[3] = -sv[3];
            opb[0] = qv[1];  opb[1] = qv[0];  opb[2] = qv[3];  opb[3] = qv[2];
          end
          2'd2: begin
            opa[1] = -sv[1]; opa[2] = sv[2];  opa[3] = sv[3];
            opb[0] = qv[2];  opb[1] = qv[3];  opb[2] = qv[0];  opb[3] = qv[1];
          end
          default: begin
            opa[1] = sv[1];  opa[2] = -sv[2]; opa[3] = sv[3];
            opb[0] = qv[3];  opb[1] = qv[2];  opb[2] = qv[1];  opb[3] = qv[0];
          end
        endcase
      end
      S_PAIR: begin
        tag_in.op = OP_PAIR;
        for (int k = 0; k < 4; k++) begin
          opa[k] = ra_q[ci_q][k];
          opb[k] = rb_q[cj_q][k];
        end
      end
      S_SQR: begin
        tag_in.op = OP_SQR;
        opa[0] = $signed({2'b00, wsat[30:15]});
        opb[0] = (comp_q == 2'd0) ? $signed({2'b00, wsat[30:15]})
                                  : $signed({3'b000, wsat[14:0]});
        if (comp_q == 2'd2) begin
          opa[0] = $signed({3'b000, wsat[14:0]});
        end
      end
      default: ;
    endcase
  end

  cma_dot4 u_dot4 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .a_i    (opa),
    .b_i    (opb),
    .tag_i  (tag_in),
    .sum_o  (dsum),
    .tag_o  (tag_out)
  );

  // results of the shared unit
  assign rsum = dsum + 38'sd16384;
  assign dabs = dsum[37] ? (~dsum + 38'd1) : dsum;

  always_ff @(posedge clk_i) begin
    if (tag_out.op == OP_ROT) begin
      if (tag_out.side) begin
        rb_q[tag_out.idx[IdxW-1:0]][tag_out.comp] <= rsum[32:15];
      end else begin
        ra_q[tag_out.idx[IdxW-1:0]][tag_out.comp] <= rsum[32:15];
      end
    end
    if (in_take) begin
      best_q <= '0;
    end else if ((tag_out.op == OP_PAIR) && (dabs > best_q)) begin
      best_q <= dabs;
    end
    if (in_take) begin
      ww_q <= '0;
    end else if (tag_out.op == OP_SQR) begin
      case (tag_out.comp)
        2'd0:    ww_q <= ww_q + (61'(dsum[32:0]) << 30);
        2'd1:    ww_q <= ww_q + (61'(dsum[32:0]) << 16);
        default: ww_q <= ww_q + 61'(dsum[32:0]);
      endcase
    end
  end

  assign vrad = (61'(1) << 60) - ww_q;

  cma_acos u_acos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (acos_start),
    .w_i     (wsat),
    .v_i     (vrad),
    .stat_o  (acos_stat)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.angle_degrees <= angle_q;
      out_q.is_low_angle  <= (angle_q < thresh_q);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // checks
  a_rot_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tag_out.op == OP_ROT) |-> $past(state_q == S_ROT))
    else $error("rotation result without rotation issue");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == S_OUT))
    else $error("result appeared outside output state");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.angle_degrees <= ANGLE_MAX))
    else $error("angle above 180 degrees");

  a_acos_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acos_stat.done |-> (state_q == S_ACOS))
    else $error("arccosine finished while not awaited");

endmodule
